FILE: sv/ola_pkg.sv
// Package for the ordered list block: capacity default, item kinds,
// result status codes and the sequencer state type.
// Depends on nothing; used by the list block and its testbench.
package ola_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    K_APPEND = 2'd0,
    K_DELETE = 2'd1,
    K_SHOW   = 2'd2,
    K_UNUSED = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DELETED   = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_SHOWN     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_SHOW   = 4'b1000
  } state_t;

endpackage

FILE: sv/ola_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
module ola_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ordered_list_append_delete.sv
// Bounded ordered list of signed words with append, delete and show.
// Append: result on the cycle after start, busy never rises.
// Delete: one pass from the head to the match, then the gap behind it closes one word per
// cycle; the result comes in the first cycle with busy low.
// Show: words come out from the head, one word per cycle, each through the RAM read and output registers.
// Synchronous reset empties the list; RAM contents are left as they are.
module ordered_list_append_delete #(
  parameter int CAPACITY = ola_pkg::CAPACITY
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [1:0]                       kind,
  input  logic signed [ola_pkg::DATA_W-1:0] value,
  output logic                             valid,
  output logic [2:0]                       status,
  output logic signed [ola_pkg::DATA_W-1:0] entry,
  output logic                             last
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  ola_pkg::state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic [CW-1:0] chk_idx, chk_idx_next;
  logic          chk_valid, chk_valid_next;
  logic [ola_pkg::DATA_W-1:0] key, key_next;
  logic          valid_next, last_next;
  logic [2:0]    status_next;
  logic [ola_pkg::DATA_W-1:0] entry_next;

  logic                       we;
  logic [IW-1:0]              waddr;
  logic [ola_pkg::DATA_W-1:0] wdata;
  logic [ola_pkg::DATA_W-1:0] rdata;
  logic [CW-1:0]              wr_idx;
  logic [CW-1:0]              cnt_m1;
  logic                       issue;
  logic                       match;
  logic                       at_end;

  assign busy   = (state != ola_pkg::S_IDLE);
  assign issue  = (rd_idx < count);
  assign match  = chk_valid && (rdata == key);
  assign cnt_m1 = count - 1'b1;
  assign wr_idx = chk_idx - 1'b1;
  assign at_end = (chk_idx == cnt_m1);

  ola_ram #(
    .WIDTH (ola_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    rd_idx_next    = rd_idx;
    chk_idx_next   = chk_idx;
    chk_valid_next = 1'b0;
    key_next       = key;
    valid_next     = 1'b0;
    status_next    = status;
    entry_next     = '0;
    last_next      = 1'b0;
    we             = 1'b0;
    waddr          = count[IW-1:0];
    wdata          = value;
    unique case (state)
      ola_pkg::S_IDLE: begin
        if (start) begin
          unique case (ola_pkg::kind_t'(kind))
            ola_pkg::K_APPEND: begin
              valid_next = 1'b1;
              last_next  = 1'b1;
              if (count == CW'(CAPACITY)) begin
                status_next = ola_pkg::ST_FULL;
              end else begin
                status_next = ola_pkg::ST_ADDED;
                we          = 1'b1;
                count_next  = count + 1'b1;
              end
            end
            ola_pkg::K_DELETE, ola_pkg::K_SHOW: begin
              if (count == '0) begin
                valid_next  = 1'b1;
                last_next   = 1'b1;
                status_next = ola_pkg::ST_EMPTY;
              end else begin
                rd_idx_next = '0;
                key_next    = value;
                if (ola_pkg::kind_t'(kind) == ola_pkg::K_DELETE) begin
                  state_next = ola_pkg::S_SEARCH;
                end else begin
                  state_next = ola_pkg::S_SHOW;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ola_pkg::S_SEARCH: begin
        chk_valid_next = issue;
        chk_idx_next   = rd_idx;
        if (issue) begin
          rd_idx_next = rd_idx + 1'b1;
        end
        if (match) begin
          rd_idx_next    = chk_idx + 1'b1;
          chk_valid_next = 1'b0;
          state_next     = ola_pkg::S_SHIFT;
        end else if (chk_valid && at_end) begin
          valid_next     = 1'b1;
          last_next      = 1'b1;
          status_next    = ola_pkg::ST_NOT_FOUND;
          chk_valid_next = 1'b0;
          state_next     = ola_pkg::S_IDLE;
        end
      end
      ola_pkg::S_SHIFT: begin
        chk_valid_next = issue;
        chk_idx_next   = rd_idx;
        if (issue) begin
          rd_idx_next = rd_idx + 1'b1;
        end
        if (chk_valid) begin
          we    = 1'b1;
          waddr = wr_idx[IW-1:0];
          wdata = rdata;
        end
        if (!issue && !chk_valid) begin
          valid_next  = 1'b1;
          last_next   = 1'b1;
          status_next = ola_pkg::ST_DELETED;
          count_next  = cnt_m1;
          state_next  = ola_pkg::S_IDLE;
        end
      end
      ola_pkg::S_SHOW: begin
        chk_valid_next = issue;
        chk_idx_next   = rd_idx;
        if (issue) begin
          rd_idx_next = rd_idx + 1'b1;
        end
        if (chk_valid) begin
          valid_next  = 1'b1;
          status_next = ola_pkg::ST_SHOWN;
          entry_next  = rdata;
          last_next   = at_end;
          if (at_end) begin
            chk_valid_next = 1'b0;
            state_next     = ola_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_next = ola_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ola_pkg::S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      valid     <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      chk_valid <= chk_valid_next;
      valid     <= valid_next;
    end
    rd_idx  <= rd_idx_next;
    chk_idx <= chk_idx_next;
    key     <= key_next;
    status  <= status_next;
    entry   <= entry_next;
    last    <= last_next;
  end

  // The list never holds more words than it has room for.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("list count exceeds capacity");

  // Only a show produces more than one result per item.
  a_multi_is_show: assert property (@(posedge clk) disable iff (rst)
    (valid && !last) |-> (status == ola_pkg::ST_SHOWN))
    else $error("non-final result that is not a shown word");

  // An accepted append with room is reported as added on the next cycle.
  a_append_added: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind == ola_pkg::K_APPEND && count != CW'(CAPACITY)) |=>
    (valid && last && status == ola_pkg::ST_ADDED))
    else $error("append not reported as added");

  // A successful delete shortens the list by exactly one word.
  a_delete_count: assert property (@(posedge clk) disable iff (rst)
    (valid && status == ola_pkg::ST_DELETED) |-> (count + 1'b1 == $past(count)))
    else $error("delete did not shorten the list by one");

  // No result is produced while a delete stays in the shift state, closing the gap.
  a_quiet_delete: assert property (@(posedge clk) disable iff (rst)
    (state == ola_pkg::S_SHIFT && $past(state) == ola_pkg::S_SHIFT) |-> !valid)
    else $error("result emitted during delete shift");

endmodule

FILE: verif/tb_ordered_list_append_delete.sv
// Self-checking testbench for the ordered list block: appends, deletes and shows
// driven as a directed run, then in random bursts, with every result checked against
// a tracked copy of the list. Depends on ola_pkg and ordered_list_append_delete.
module tb_ordered_list_append_delete;

  localparam int CAP = ola_pkg::CAPACITY;
  localparam int DRAIN = 2 * CAP + 8;
  localparam int RANDOM_WORDS = 130;

  typedef enum {M_MIXED, M_GROW, M_SHRINK} mix_t;

  typedef struct {
    ola_pkg::status_t status;
    logic [ola_pkg::DATA_W-1:0] entry;
    logic last;
  } list_result_t;

  class list_tracker;
    int capacity;
    logic [ola_pkg::DATA_W-1:0] stored[$];
    list_result_t pending[$];
    int words;
    int results;
    int mismatches;
    int full_hits;

    function new(int cap);
      capacity = cap;
      words = 0;
      results = 0;
      mismatches = 0;
      full_hits = 0;
    endfunction

    function void push_result(ola_pkg::status_t st, logic [ola_pkg::DATA_W-1:0] e, logic l);
      list_result_t r;
      r.status = st;
      r.entry = e;
      r.last = l;
      pending.push_back(r);
    endfunction

    function void note_word(ola_pkg::kind_t k, logic [ola_pkg::DATA_W-1:0] v);
      int idx;
      words++;
      case (k)
        ola_pkg::K_APPEND: begin
          if (stored.size() >= capacity) begin
            full_hits++;
            push_result(ola_pkg::ST_FULL, '0, 1'b1);
          end else begin
            stored.push_back(v);
            push_result(ola_pkg::ST_ADDED, '0, 1'b1);
          end
        end
        ola_pkg::K_DELETE: begin
          idx = -1;
          foreach (stored[i]) begin
            if (idx < 0 && stored[i] == v) idx = i;
          end
          if (stored.size() == 0) begin
            push_result(ola_pkg::ST_EMPTY, '0, 1'b1);
          end else if (idx < 0) begin
            push_result(ola_pkg::ST_NOT_FOUND, '0, 1'b1);
          end else begin
            stored.delete(idx);
            push_result(ola_pkg::ST_DELETED, '0, 1'b1);
          end
        end
        ola_pkg::K_SHOW: begin
          if (stored.size() == 0) begin
            push_result(ola_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            foreach (stored[i]) begin
              push_result(ola_pkg::ST_SHOWN, stored[i], i == stored.size() - 1);
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void report(string what, list_result_t want, logic [2:0] st,
                         logic [ola_pkg::DATA_W-1:0] e, logic l);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t %s: want st %0d entry %0d last %0d, got st %0d entry %0d last %0d",
                 $realtime, what, want.status, $signed(want.entry), want.last,
                 st, $signed(e), l);
      end
    endfunction

    function void check_word(logic [2:0] st, logic [ola_pkg::DATA_W-1:0] e, logic l);
      list_result_t want;
      results++;
      if (pending.size() == 0) begin
        want.status = ola_pkg::ST_ADDED;
        want.entry = '0;
        want.last = 1'b0;
        report("result with nothing outstanding", want, st, e, l);
      end else begin
        want = pending.pop_front();
        if (st !== want.status || e !== want.entry || l !== want.last) begin
          report("result mismatch", want, st, e, l);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] kind;
  logic signed [ola_pkg::DATA_W-1:0] value;
  logic valid;
  logic [2:0] status;
  logic signed [ola_pkg::DATA_W-1:0] entry;
  logic last;

  list_tracker tracker;
  int burst_left;
  int counted;

  ordered_list_append_delete #(
    .CAPACITY(CAP)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .value(value),
    .valid(valid),
    .status(status),
    .entry(entry),
    .last(last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (valid) tracker.check_word(status, entry, last);
      if (start && !busy) tracker.note_word(ola_pkg::kind_t'(kind), value);
    end
  end

  task automatic send_word(input ola_pkg::kind_t k, input logic [ola_pkg::DATA_W-1:0] v);
    start <= 1'b1;
    kind <= k;
    value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    counted++;
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 5) == 0) repeat ($urandom_range(15, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  function automatic logic [ola_pkg::DATA_W-1:0] pick_value();
    logic [ola_pkg::DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom_range(0, 7) - 3;
      4: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          default: v = 32'hffff_ffff;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [ola_pkg::DATA_W-1:0] pick_victim();
    if (tracker.stored.size() > 0 && $urandom_range(0, 9) < 7) begin
      return tracker.stored[$urandom_range(0, tracker.stored.size() - 1)];
    end
    return pick_value();
  endfunction

  task automatic random_word(input mix_t mode);
    int r;
    ola_pkg::kind_t k;
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_word(ola_pkg::K_UNUSED, $urandom);
    end else begin
      r = $urandom_range(0, 99);
      case (mode)
        M_GROW: k = (r < 80) ? ola_pkg::K_APPEND : (r < 90) ? ola_pkg::K_DELETE : ola_pkg::K_SHOW;
        M_SHRINK: k = (r < 90) ? ola_pkg::K_DELETE : (r < 95) ? ola_pkg::K_APPEND : ola_pkg::K_SHOW;
        default: k = (r < 45) ? ola_pkg::K_APPEND : (r < 85) ? ola_pkg::K_DELETE : ola_pkg::K_SHOW;
      endcase
      send_word(k, (k == ola_pkg::K_DELETE) ? pick_victim() : pick_value());
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    kind <= ola_pkg::K_APPEND;
    value <= '0;
    tracker = new(CAP);
    burst_left = 4;
    counted = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_word(ola_pkg::K_SHOW, 32'h0000_0000);
    send_word(ola_pkg::K_DELETE, 32'h0000_0005);
    send_word(ola_pkg::K_UNUSED, 32'h0000_0005);
    send_word(ola_pkg::K_APPEND, 32'h8000_0000);
    send_word(ola_pkg::K_APPEND, 32'h7fff_ffff);
    send_word(ola_pkg::K_APPEND, 32'h0000_0000);
    send_word(ola_pkg::K_APPEND, 32'hffff_ffff);
    send_word(ola_pkg::K_APPEND, 32'h0000_0005);
    send_word(ola_pkg::K_APPEND, 32'h7fff_ffff);
    send_word(ola_pkg::K_SHOW, 32'hffff_ffff);
    send_word(ola_pkg::K_DELETE, 32'h0000_04d2);
    send_word(ola_pkg::K_DELETE, 32'h7fff_ffff);
    send_word(ola_pkg::K_DELETE, 32'h8000_0000);
    send_word(ola_pkg::K_DELETE, 32'h7fff_ffff);
    send_word(ola_pkg::K_SHOW, 32'h0000_0000);
    send_word(ola_pkg::K_UNUSED, 32'hffff_ffff);
    send_word(ola_pkg::K_DELETE, 32'h0000_0000);
    send_word(ola_pkg::K_DELETE, 32'hffff_ffff);
    send_word(ola_pkg::K_DELETE, 32'h0000_0005);
    send_word(ola_pkg::K_DELETE, 32'h0000_0005);
    send_word(ola_pkg::K_SHOW, 32'h0000_0000);

    repeat (15) random_word(M_MIXED);
    // Fill the list to capacity, then push against the limit.
    while (tracker.stored.size() < CAP) send_word(ola_pkg::K_APPEND, pick_value());
    repeat (3) send_word(ola_pkg::K_APPEND, pick_value());
    send_word(ola_pkg::K_SHOW, $urandom);
    while (tracker.stored.size() > 0) random_word(M_SHRINK);
    send_word(ola_pkg::K_DELETE, pick_value());
    send_word(ola_pkg::K_SHOW, $urandom);
    while (counted < RANDOM_WORDS) begin
      mix_t mode;
      mode = mix_t'($urandom_range(0, 2));
      repeat ($urandom_range(8, 20)) begin
        if (counted < RANDOM_WORDS) random_word(mode);
      end
    end

    if (start) start <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Run covered %0d accepted words and %0d checked results,", tracker.words,
             tracker.results);
    $display("with the full list hit %0d times; mismatches counted: %0d.",
             tracker.full_hits, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending.size() == 0) begin
      $display("tb_ordered_list_append_delete: PASS");
    end else begin
      $display("tb_ordered_list_append_delete: FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results outstanding.", tracker.pending.size());
    $display("tb_ordered_list_append_delete: FAIL");
    $finish;
  end

endmodule
